[hdl/keyed_table_shift_delete_macros.svh]
// Assertion macros used by the checker file of the keyed table.
`ifndef KEYED_TABLE_SHIFT_DELETE_MACROS_SVH
`define KEYED_TABLE_SHIFT_DELETE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define KTSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("keyed table checker: property failed");

// Check a property on every clock edge, reset included.
`define KTSD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("keyed table checker: property failed during reset");

`endif

[hdl/ktsd_pkg.sv]
package ktsd_pkg;

   // field widths of the command and response transactions
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int PRICE_W  = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 8;

   localparam int DEFAULT_CAPACITY = 128;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

   // write enables from the sequencer to the two table memories
   typedef struct packed {
      logic key_we;
      logic price_we;
   } ktsd_wr_type;

endpackage

[hdl/ktsd_ram.sv]
module ktsd_ram #(
   parameter int WIDTH = ktsd_pkg::KEY_W,
   parameter int DEPTH = ktsd_pkg::DEFAULT_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, read one entry with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ktsd_ctrl.sv]
module ktsd_ctrl #(
   parameter int CAPACITY = ktsd_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ktsd_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [ktsd_pkg::KEY_W-1:0]   req_key,
   input  logic [ktsd_pkg::PRICE_W-1:0]        req_price,
   input  logic [ktsd_pkg::POS_W-1:0]          req_position,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ktsd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ktsd_pkg::TOTAL_W-1:0]        rsp_entry_total,
   output logic signed [ktsd_pkg::KEY_W-1:0]   rsp_read_key,
   output logic [ktsd_pkg::PRICE_W-1:0]        rsp_read_price,
   // table memories
   output ktsd_pkg::ktsd_wr_type               mem_wr,
   output logic [$clog2(CAPACITY)-1:0]         mem_wr_addr,
   output logic signed [ktsd_pkg::KEY_W-1:0]   mem_wr_key,
   output logic [ktsd_pkg::PRICE_W-1:0]        mem_wr_price,
   output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
   input  logic signed [ktsd_pkg::KEY_W-1:0]   mem_rd_key,
   input  logic [ktsd_pkg::PRICE_W-1:0]        mem_rd_price
);

   import ktsd_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic signed [KEY_W-1:0] res_key_ff, res_key_in;
   logic [PRICE_W-1:0]  res_price_ff, res_price_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [PRICE_W-1:0]  rsp_price_ff, rsp_price_in;

   logic [CW-1:0]       next_idx;
   logic [CW-1:0]       next2_idx;
   logic                more_next;
   logic                more_next2;
   logic                key_hit;

   // one transaction at a time: no read can meet a pending write to the same entry
   assign req_stall  = (state_ff != S_IDLE);

   assign next_idx   = CW'(idx_ff) + CW'(1);
   assign next2_idx  = next_idx + CW'(1);
   assign more_next  = (next_idx < count_ff);
   assign more_next2 = (next2_idx < count_ff);
   assign key_hit    = (mem_rd_key == key_ff);

   // sequence insert, read, search, shift and response
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      price_in      = price_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_price_in  = res_price_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_price_in  = rsp_price_ff;
      mem_wr        = '0;
      mem_wr_addr   = idx_ff;
      mem_wr_key    = key_ff;
      mem_wr_price  = price_ff;
      mem_rd_addr   = idx_ff;

      // drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_cmd;
               key_in        = req_key;
               price_in      = req_price;
               res_status_in = ST_OK;
               res_key_in    = '0;
               res_price_in  = '0;
               state_in      = S_DONE;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_wr.key_we   = 1'b1;
                        mem_wr.price_we = 1'b1;
                        mem_wr_addr     = count_ff[AW-1:0];
                        mem_wr_key      = req_key;
                        mem_wr_price    = req_price;
                        count_in        = count_ff + CW'(1);
                     end
                  end
                  CMD_UPDATE, CMD_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        mem_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = S_SEARCH;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else if (CMPW'(req_position) >= CMPW'(count_ff)) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        mem_rd_addr = AW'(req_position);
                        state_in    = S_READ;
                     end
                  end
               endcase
            end
         end

         // capture the entry at the requested position
         S_READ: begin
            res_key_in   = mem_rd_key;
            res_price_in = mem_rd_price;
            state_in     = S_DONE;
         end

         // compare one entry per cycle, prefetch the next
         S_SEARCH: begin
            if (key_hit) begin
               if (cmd_ff == CMD_UPDATE) begin
                  mem_wr.price_we = 1'b1;
                  state_in        = S_DONE;
               end else if (more_next) begin
                  mem_rd_addr = next_idx[AW-1:0];
                  state_in    = S_SHIFT;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            end else if (more_next) begin
               mem_rd_addr = next_idx[AW-1:0];
               idx_in      = next_idx[AW-1:0];
            end else begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_DONE;
            end
         end

         // move entry idx+1 down to idx, read idx+2 in the same cycle
         S_SHIFT: begin
            mem_wr.key_we   = 1'b1;
            mem_wr.price_we = 1'b1;
            mem_wr_key      = mem_rd_key;
            mem_wr_price    = mem_rd_price;
            idx_in          = next_idx[AW-1:0];
            if (more_next2) begin
               mem_rd_addr = next2_idx[AW-1:0];
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_total_in  = TOTAL_W'(count_ff);
               rsp_key_in    = res_key_ff;
               rsp_price_in  = res_price_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      price_ff      <= price_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_price_ff  <= res_price_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_price_ff  <= rsp_price_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_read_key    = rsp_key_ff;
   assign rsp_read_price  = rsp_price_ff;

endmodule

[hdl/keyed_table_shift_delete.sv]
// Keyed table with shift delete.
// Holds up to CAPACITY key/price pairs packed at positions 0..count-1.
// Command channel (req_*): one transaction carries cmd, key, price and
// position; it is taken at a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): one transaction per command with status, entry
// count after the command, and the key/price read (zero unless a read is ok).
// Insert, and any command that ends in full, empty or out of range, goes
// straight to the response; a read first fetches its entry; update and
// delete compare entries in turn from position 0, and a delete then moves
// each later entry down by one position. The single read port of the key
// and price memories means that the search and the compaction each touch
// one entry per cycle.
// Commands are handled one at a time; req_stall is high from acceptance until
// the result has moved into the response register.
// A stalled response holds in its register; the next command may already be
// accepted and worked on, and its result waits until the register is free.
// Reset clears the entry count and the response valid; memory contents are
// not cleared, since only written positions are ever read.
module keyed_table_shift_delete #(
   parameter int CAPACITY = ktsd_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ktsd_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [ktsd_pkg::KEY_W-1:0]   req_key,
   input  logic [ktsd_pkg::PRICE_W-1:0]        req_price,
   input  logic [ktsd_pkg::POS_W-1:0]          req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ktsd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ktsd_pkg::TOTAL_W-1:0]        rsp_entry_total,
   output logic signed [ktsd_pkg::KEY_W-1:0]   rsp_read_key,
   output logic [ktsd_pkg::PRICE_W-1:0]        rsp_read_price
);

   import ktsd_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   ktsd_wr_type             mem_wr;
   logic [AW-1:0]           mem_wr_addr;
   logic signed [KEY_W-1:0] mem_wr_key;
   logic [PRICE_W-1:0]      mem_wr_price;
   logic [AW-1:0]           mem_rd_addr;
   logic signed [KEY_W-1:0] mem_rd_key;
   logic [PRICE_W-1:0]      mem_rd_price;

   // sequencer with response register
   ktsd_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_price       (req_price),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_total (rsp_entry_total),
      .rsp_read_key    (rsp_read_key),
      .rsp_read_price  (rsp_read_price),
      .mem_wr          (mem_wr),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_key      (mem_wr_key),
      .mem_wr_price    (mem_wr_price),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_key      (mem_rd_key),
      .mem_rd_price    (mem_rd_price)
   );

   // key storage
   ktsd_ram #(
      .WIDTH(KEY_W),
      .DEPTH(CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_wr.key_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_key),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_key)
   );

   // price storage
   ktsd_ram #(
      .WIDTH(PRICE_W),
      .DEPTH(CAPACITY)
   ) u_price_ram (
      .clock   (clock),
      .wr_en   (mem_wr.price_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_price),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_price)
   );

endmodule

[hdl/ktsd_checker.sv]
`include "keyed_table_shift_delete_macros.svh"

module ktsd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ktsd_pkg::STATUS_W-1:0]       rsp_status,
   input logic [ktsd_pkg::TOTAL_W-1:0]        rsp_entry_total,
   input logic signed [ktsd_pkg::KEY_W-1:0]   rsp_read_key,
   input logic [ktsd_pkg::PRICE_W-1:0]        rsp_read_price
);

   import ktsd_pkg::*;

   // a stalled response transaction holds its payload
   `KTSD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_entry_total) && $stable(rsp_read_key) && $stable(rsp_read_price)))

   // reset leaves no response pending
   `KTSD_ASSERT_ALWAYS(a_rst_idle, clock, reset |=> !rsp_valid)

   // a valid response always carries one of the defined status codes
   `KTSD_ASSERT(a_status_code, clock, reset, rsp_valid |-> (rsp_status <= ST_RANGE))

   // read fields are zero unless the command succeeded
   `KTSD_ASSERT(a_zero_fields, clock, reset, (rsp_valid && (rsp_status != ST_OK)) |-> ((rsp_read_key == '0) && (rsp_read_price == '0)))

   // a command in progress blocks the next one
   `KTSD_ASSERT(a_one_inflight, clock, reset, (req_valid && !req_stall) |=> req_stall)

endmodule

bind keyed_table_shift_delete ktsd_checker u_ktsd_checker (.*);

[tb/keyed_table_shift_delete_test.sv]
`timescale 1ns / 1ps

module keyed_table_shift_delete_test;
   import ktsd_pkg::*;

   localparam int TABLE_DEPTH = DEFAULT_CAPACITY;

   // expected response of one command
   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic [TOTAL_W-1:0]        total;
      logic signed [KEY_W-1:0]   rkey;
      logic [PRICE_W-1:0]        rprice;
   } table_reply_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_cmd = CMD_READ;
   logic signed [KEY_W-1:0]   req_key = '0;
   logic [PRICE_W-1:0]        req_price = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [TOTAL_W-1:0]        rsp_entry_total;
   logic signed [KEY_W-1:0]   rsp_read_key;
   logic [PRICE_W-1:0]        rsp_read_price;

   // shadow copy of the table contents
   logic signed [KEY_W-1:0]   held_key [TABLE_DEPTH];
   logic [PRICE_W-1:0]        held_price [TABLE_DEPTH];
   int                        held_count = 0;

   table_reply_type           reply_queue [$];
   int                        mismatch_count = 0;
   int                        send_idle_pct = 0;
   int                        stall_pct = 0;

   keyed_table_shift_delete #(
      .CAPACITY(TABLE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_key(req_key),
      .req_price(req_price),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_total(rsp_entry_total),
      .rsp_read_key(rsp_read_key),
      .rsp_read_price(rsp_read_price)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // end the run if it hangs
   initial begin
      #(64'd50_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // apply one command to the shadow table and return its response
   function automatic table_reply_type apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic signed [KEY_W-1:0] key,
                                                     input logic [PRICE_W-1:0] price,
                                                     input logic [POS_W-1:0] pos);
      table_reply_type r;
      int hit;
      r.status = ST_OK;
      r.rkey   = '0;
      r.rprice = '0;
      hit = -1;
      // linear search for the lowest matching position
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_key[i] == key) hit = i;
      end
      case (cmd)
         CMD_INSERT: begin
            if (held_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held_key[held_count]   = key;
               held_price[held_count] = price;
               held_count++;
            end
         end
         CMD_UPDATE: begin
            if (held_count == 0) r.status = ST_EMPTY;
            else if (hit < 0) r.status = ST_NOTFOUND;
            else held_price[hit] = price;
         end
         CMD_DELETE: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else if (hit < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               // close the gap left by the deleted entry
               for (int i = hit; i < held_count - 1; i++) begin
                  held_key[i]   = held_key[i + 1];
                  held_price[i] = held_price[i + 1];
               end
               held_count--;
            end
         end
         default: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else if (int'(pos) >= held_count) begin
               r.status = ST_RANGE;
            end else begin
               r.rkey   = held_key[pos];
               r.rprice = held_price[pos];
            end
         end
      endcase
      r.total = TOTAL_W'(held_count);
      return r;
   endfunction

   // mostly a key that is held, else a small pool or any value
   function automatic logic signed [KEY_W-1:0] pick_table_key();
      logic signed [KEY_W-1:0] k;
      if (held_count > 0 && $urandom_range(0, 99) < 80) begin
         k = held_key[$urandom_range(0, held_count - 1)];
      end else if ($urandom_range(0, 1) == 0) begin
         k = $urandom_range(0, 15);
         k = k - 8;
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   // drive one command transaction and record its expected response
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [KEY_W-1:0] key,
                               input logic [PRICE_W-1:0] price,
                               input logic [POS_W-1:0] pos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_key      <= key;
      req_price    <= price;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      reply_queue.push_back(apply_command(cmd, key, price, pos));
   endtask

   // hold off the sender until every response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (reply_queue.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endtask

   // check each response transaction against the oldest expectation
   always @(posedge clock) begin : check_responses
      table_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_queue.size() == 0) begin
            $error("response transaction with no command pending");
            mismatch_count++;
         end else begin
            want = reply_queue.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("entry_total", 32'(want.total), 32'(rsp_entry_total));
            compare_field("read_key", want.rkey, rsp_read_key);
            compare_field("read_price", want.rprice, rsp_read_price);
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // update, delete and read on an empty table
   task automatic test_empty_table();
      send_command(CMD_UPDATE, 32'sd5, 32'd1, 7'd0);
      send_command(CMD_DELETE, 32'sd5, 32'd0, 7'd0);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd0);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd127);
   endtask

   // extreme keys and prices, reads at the ends of the range
   task automatic test_extreme_values();
      send_command(CMD_INSERT, 32'sh8000_0000, 32'h0000_0000, 7'd127);
      send_command(CMD_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 7'd0);
      send_command(CMD_INSERT, 32'sd0, 32'h0000_0001, 7'd0);
      send_command(CMD_INSERT, -32'sd1, 32'h8000_0000, 7'd0);
      send_command(CMD_INSERT, 32'sd7, 32'd10, 7'd0);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd0);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd4);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd5);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd127);
   endtask

   // duplicates act on the lowest position, misses leave the table alone
   task automatic test_duplicate_keys();
      send_command(CMD_INSERT, 32'sd7, 32'd20, 7'd0);
      send_command(CMD_UPDATE, 32'sd7, 32'd99, 7'd0);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd4);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd5);
      send_command(CMD_UPDATE, 32'sd12345, 32'd3, 7'd0);
      send_command(CMD_DELETE, 32'sd42, 32'd0, 7'd0);
      send_command(CMD_DELETE, 32'sd7, 32'd0, 7'd0);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd4);
      send_command(CMD_DELETE, 32'sh8000_0000, 32'd0, 7'd0);
      send_command(CMD_DELETE, -32'sd1, 32'd0, 7'd0);
      send_command(CMD_DELETE, 32'sd7, 32'd0, 7'd0);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd0);
   endtask

   // fill to capacity, push past it, then empty most of it again
   task automatic test_full_table();
      while (held_count < TABLE_DEPTH) begin
         send_command(CMD_INSERT, $urandom, $urandom, POS_W'($urandom_range(0, 127)));
      end
      repeat (3) send_command(CMD_INSERT, $urandom, $urandom,
                              POS_W'($urandom_range(0, 127)));
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd127);
      send_command(CMD_READ, 32'sd0, 32'd0, 7'd0);
      send_command(CMD_UPDATE, held_key[TABLE_DEPTH - 1], $urandom, 7'd0);
      send_command(CMD_UPDATE, $urandom, $urandom, 7'd0);
      // longest compaction: delete the first entry of a full table
      send_command(CMD_DELETE, held_key[0], $urandom, 7'd0);
      send_command(CMD_INSERT, $urandom, $urandom, 7'd0);
      send_command(CMD_DELETE, held_key[TABLE_DEPTH - 1], $urandom, 7'd0);
      while (held_count > 16) begin
         send_command(CMD_DELETE, pick_table_key(), $urandom,
                      POS_W'($urandom_range(0, 127)));
      end
   endtask

   // random command mix that keeps the table at a moderate fill
   task automatic test_random_mix(input int count);
      logic [CMD_W-1:0]        cmd;
      logic signed [KEY_W-1:0] key;
      logic [PRICE_W-1:0]      price;
      logic [POS_W-1:0]        pos;
      int                      r;
      int                      insert_weight;
      repeat (count) begin
         r = $urandom_range(0, 99);
         insert_weight = (held_count < 32) ? 40 : 15;
         if (r < insert_weight) cmd = CMD_INSERT;
         else if (r < insert_weight + 20) cmd = CMD_UPDATE;
         else if (r < insert_weight + 45) cmd = CMD_DELETE;
         else cmd = CMD_READ;
         if (cmd == CMD_INSERT && $urandom_range(0, 99) < 70) key = $urandom;
         else key = pick_table_key();
         case ($urandom_range(0, 15))
            0: price = '0;
            1: price = '1;
            default: price = $urandom;
         endcase
         if (held_count > 0 && $urandom_range(0, 99) < 70) begin
            pos = POS_W'($urandom_range(0, held_count - 1));
         end else begin
            pos = POS_W'($urandom_range(0, 127));
         end
         send_command(cmd, key, price, pos);
      end
   endtask

   // drain, let the block settle, then report
   task automatic finish_run();
      wait_for_drain();
      repeat (2 * TABLE_DEPTH + 16) @(posedge clock);
      if (mismatch_count == 0 && reply_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 0;
      stall_pct     = 0;
      test_empty_table();
      test_extreme_values();
      test_duplicate_keys();
      wait_for_drain();

      send_idle_pct = 19;
      stall_pct     = 19;
      test_full_table();
      wait_for_drain();

      // idling phases: none, sender, receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 80 : (phase == 3) ? 19 : 0;
         stall_pct     = (phase == 2) ? 80 : (phase == 3) ? 19 : 0;
         test_random_mix(330);
         wait_for_drain();
      end

      finish_run();
   end

endmodule

[files.f]
+incdir+hdl
hdl/ktsd_pkg.sv
hdl/ktsd_ram.sv
hdl/ktsd_ctrl.sv
hdl/keyed_table_shift_delete.sv
hdl/ktsd_checker.sv
tb/keyed_table_shift_delete_test.sv
